// ===== rtl/core/ipd_pkg.sv =====
package ipd_pkg;

	localparam int BUF_BYTES_DEF    = 2048;
	localparam int HEADER_BYTES_DEF = 20;

	localparam logic [7:0] START_BYTE = 8'h45;

	localparam int LEN_W   = 12;
	localparam int INDEX_W = 11;

	// result queue between the front and the output side
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		EV_TAKEN    = 2'd0,
		EV_DONE     = 2'd1,
		EV_OVERFLOW = 2'd2,
		EV_READ     = 2'd3
	} ev_t;

	typedef struct packed {
		logic               mode;
		logic [7:0]         rx_byte;
		logic [INDEX_W-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		ev_t              event_res;
		logic [7:0]       read_data;
		logic [LEN_W-1:0] pkt_len;
	} out_item_t;

endpackage

// ===== rtl/core/ipd_ram.sv =====
module ipd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/core/ipd_front.sv =====
module ipd_front #(
	parameter int BUF_BYTES    = ipd_pkg::BUF_BYTES_DEF,
	parameter int HEADER_BYTES = ipd_pkg::HEADER_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ipd_pkg::in_item_t       in_item,
	input  logic [ipd_pkg::Q_CW-1:0] q_level,
	output logic                    push_valid,
	output ipd_pkg::out_item_t      push_item
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam int CW = $clog2(BUF_BYTES + 1);

	typedef enum logic [1:0] {
		IDLE   = 2'd0,
		HEADER = 2'd1,
		DATA   = 2'd2
	} phase_t;

	phase_t                      phase_q, phase_n;
	logic [CW-1:0]               count_q, count_n, count_inc;
	logic [15:0]                 len_q, len_n;
	logic                        v_s1;
	ipd_pkg::ev_t                ev_s1, ev_n;
	logic [ipd_pkg::LEN_W-1:0]   plen_s1, plen_n;
	logic                        rd_ok_s1, rd_ok;
	logic                        accept;
	logic                        ram_en, ram_we;
	logic [AW-1:0]               ram_addr;
	logic [7:0]                  ram_rdata;

	// room for the item in flight plus this one, ignoring any pop
	assign in_ready = (32'(q_level) + 32'(v_s1)) < ipd_pkg::Q_DEPTH;
	assign accept   = in_valid && in_ready;

	assign count_inc = count_q + CW'(1);
	assign rd_ok     = 32'(in_item.read_index) < BUF_BYTES;

	always_comb begin
		phase_n = phase_q;
		count_n = count_q;
		len_n   = len_q;
		ev_n    = ipd_pkg::EV_TAKEN;
		plen_n  = '0;
		ram_we  = 1'b0;
		if (in_item.mode) begin
			ev_n = ipd_pkg::EV_READ;
		end else begin
			case (phase_q)
				HEADER, DATA: begin
					if (32'(count_q) >= BUF_BYTES) begin
						ev_n    = ipd_pkg::EV_OVERFLOW;
						count_n = '0;
						phase_n = IDLE;
					end else begin
						ram_we  = 1'b1;
						count_n = count_inc;
						if (phase_q == HEADER) begin
							// length field arrives in header bytes 2 and 3
							if (count_q == CW'(2)) len_n[15:8] = in_item.rx_byte;
							if (count_q == CW'(3)) len_n[7:0]  = in_item.rx_byte;
							if (32'(count_inc) == HEADER_BYTES) phase_n = DATA;
						end else if (32'(count_inc) >= 32'(len_q)) begin
							ev_n    = ipd_pkg::EV_DONE;
							plen_n  = ipd_pkg::LEN_W'(count_inc);
							count_n = '0;
							phase_n = IDLE;
						end
					end
				end
				default: begin
					if (in_item.rx_byte == ipd_pkg::START_BYTE) begin
						ram_we  = 1'b1;
						count_n = CW'(1);
						phase_n = HEADER;
					end
				end
			endcase
		end
	end

	// count is zero in idle, so it addresses the start byte too
	assign ram_addr = in_item.mode ? AW'(in_item.read_index) : count_q[AW-1:0];
	assign ram_en   = accept && (in_item.mode || ram_we);

	ipd_ram #(
		.WIDTH(8),
		.DEPTH(BUF_BYTES)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(in_item.rx_byte),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= IDLE;
			count_q  <= '0;
			len_q    <= '0;
			v_s1     <= 1'b0;
			ev_s1    <= ipd_pkg::EV_TAKEN;
			plen_s1  <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				phase_q  <= phase_n;
				count_q  <= count_n;
				len_q    <= len_n;
				ev_s1    <= ev_n;
				plen_s1  <= plen_n;
				rd_ok_s1 <= in_item.mode && rd_ok;
			end
		end
	end

	assign push_valid          = v_s1;
	assign push_item.event_res = ev_s1;
	assign push_item.read_data = rd_ok_s1 ? ram_rdata : 8'h00;
	assign push_item.pkt_len   = plen_s1;

	a_data_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == DATA) |-> (32'(count_q) >= HEADER_BYTES))
		else $error("data phase entered before header complete");

	a_accept_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item produced no result");

	a_overflow_at_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ev_s1 == ipd_pkg::EV_OVERFLOW) |-> (32'($past(count_q)) >= BUF_BYTES))
		else $error("overflow reported with buffer not full");

endmodule

// ===== rtl/core/ipd_queue.sv =====
module ipd_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push_valid,
	input  ipd_pkg::out_item_t       push_item,
	output logic [ipd_pkg::Q_CW-1:0] q_level,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ipd_pkg::out_item_t       out_item
);

	ipd_pkg::out_item_t            entry_q [ipd_pkg::Q_DEPTH];
	logic [ipd_pkg::Q_AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [ipd_pkg::Q_CW-1:0]      count_q;
	logic                          pop;

	assign out_valid = count_q != '0;
	assign out_item  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign q_level   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) wr_ptr_q <= wr_ptr_q + ipd_pkg::Q_AW'(1);
			if (pop)        rd_ptr_q <= rd_ptr_q + ipd_pkg::Q_AW'(1);
			case ({push_valid, pop})
				2'b10:   count_q <= count_q + ipd_pkg::Q_CW'(1);
				2'b01:   count_q <= count_q - ipd_pkg::Q_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) entry_q[wr_ptr_q] <= push_item;
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (32'(count_q) < ipd_pkg::Q_DEPTH))
		else $error("result queue overrun");

endmodule

// ===== rtl/core/ipv4_packet_deframer.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_item  (ipd_pkg::in_item_t)
// out       output     out_valid / out_ready  out_item (ipd_pkg::out_item_t)
//
// One item per cycle sustained while out_ready keeps the result queue from filling;
// each item makes exactly one transfer on out. The single-port packet buffer
// gives one access per item with a registered read into the front stage,
// then the result enters the queue, whose count drives out_valid.
// in_ready drops only when the four-entry result queue plus the item in
// flight would fill it. Reset clears phase, count and queue; the buffer is
// not cleared and takes no clearing pass.
module ipv4_packet_deframer #(
	parameter int BUF_BYTES    = ipd_pkg::BUF_BYTES_DEF,
	parameter int HEADER_BYTES = ipd_pkg::HEADER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ipd_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ipd_pkg::out_item_t out_item
);

	logic                     push_valid;
	ipd_pkg::out_item_t       push_item;
	logic [ipd_pkg::Q_CW-1:0] q_level;

	ipd_front #(
		.BUF_BYTES   (BUF_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.q_level   (q_level),
		.push_valid(push_valid),
		.push_item (push_item)
	);

	ipd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_item (push_item),
		.q_level   (q_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== dv/ipv4_packet_deframer_tb.sv =====
`timescale 1ns / 1ps

module ipv4_packet_deframer_tb;

	localparam int BUF        = ipd_pkg::BUF_BYTES_DEF;
	localparam int HDR        = ipd_pkg::HEADER_BYTES_DEF;
	localparam int IW         = ipd_pkg::INDEX_W;
	localparam int IDLE_PCT   = 34;
	localparam int RAND_ITEMS = 1400;
	localparam int QUIET_MAX  = 2000;
	localparam int HOLD_AT    = 4800;
	localparam int HOLD_LEN   = 80;
	// both sides run without idling inside this transfer range
	localparam int BURST_LO   = 300;
	localparam int BURST_HI   = 1300;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEADER,
		ST_DATA
	} rx_phase_t;

	typedef struct {
		ipd_pkg::in_item_t item;
		bit                drain;
	} pend_t;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	ipd_pkg::in_item_t  in_item  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ipd_pkg::out_item_t out_item;

	pend_t              pend_q[$];
	ipd_pkg::out_item_t result_q[$];
	bit                 drain_next;
	int                 n_items;
	int                 err_cnt;
	int                 in_cnt;
	int                 res_cnt;
	int                 hold_left;
	bit                 hold_done;
	int                 quiet_cycles;

	// deframer state as the block should hold it
	rx_phase_t  rx_phase;
	int         rx_cnt;
	int         rx_total;
	logic [7:0] pkt_mem [BUF];

	ipv4_packet_deframer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic ipd_pkg::out_item_t deframe_byte(ipd_pkg::in_item_t it);
		ipd_pkg::out_item_t r;
		r           = '0;
		r.event_res = ipd_pkg::EV_TAKEN;
		if (it.mode) begin
			r.event_res = ipd_pkg::EV_READ;
			if (int'(it.read_index) < BUF)
				r.read_data = pkt_mem[it.read_index];
		end else if (rx_phase == ST_IDLE) begin
			if (it.rx_byte == ipd_pkg::START_BYTE) begin
				pkt_mem[0] = it.rx_byte;
				rx_cnt     = 1;
				rx_phase   = ST_HEADER;
			end
		end else if (rx_cnt >= BUF) begin
			// buffer full: drop the packet
			rx_cnt      = 0;
			rx_phase    = ST_IDLE;
			r.event_res = ipd_pkg::EV_OVERFLOW;
		end else begin
			pkt_mem[rx_cnt] = it.rx_byte;
			rx_cnt++;
			if (rx_phase == ST_HEADER) begin
				if (rx_cnt == HDR) begin
					rx_total = {pkt_mem[2], pkt_mem[3]};
					rx_phase = ST_DATA;
				end
			end else if (rx_cnt >= rx_total) begin
				r.event_res = ipd_pkg::EV_DONE;
				r.pkt_len   = ipd_pkg::LEN_W'(rx_cnt);
				rx_cnt      = 0;
				rx_phase    = ST_IDLE;
			end
		end
		return r;
	endfunction

	task automatic queue_item(bit mode, logic [7:0] b, logic [IW-1:0] idx,
	                          bit counted);
		pend_t p;
		p.item.mode       = mode;
		p.item.rx_byte    = b;
		p.item.read_index = idx;
		p.drain           = drain_next;
		drain_next        = 1'b0;
		pend_q.push_back(p);
		if (counted)
			n_items++;
	endtask

	task automatic queue_read(logic [IW-1:0] idx);
		queue_item(1'b1, 8'($urandom), idx, 1'b1);
	endtask

	// idle byte that never starts a packet
	task automatic queue_noise();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == ipd_pkg::START_BYTE);
		queue_item(1'b0, b, IW'($urandom), 1'b0);
	endtask

	task automatic queue_packet(int len_field, bit with_reads);
		int n;
		logic [7:0] b;
		if (len_field <= HDR)
			n = HDR + 1;
		else if (len_field > BUF)
			n = BUF + 1;
		else
			n = len_field;
		for (int k = 0; k < n; k++) begin
			if (k == 0)
				b = ipd_pkg::START_BYTE;
			else if (k == 2)
				b = len_field[15:8];
			else if (k == 3)
				b = len_field[7:0];
			else
				b = 8'($urandom);
			if (with_reads && k > 0 && $urandom_range(99) < 6)
				queue_read(IW'($urandom_range(BUF - 1)));
			queue_item(1'b0, b, IW'($urandom), 1'b1);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			rx_phase = ST_IDLE;
			rx_cnt   = 0;
			rx_total = 0;
			in_cnt   = 0;
		end else begin
			if (in_valid && in_ready) begin
				result_q.push_back(deframe_byte(in_item));
				in_cnt++;
			end
			if (!(in_valid && !in_ready)) begin
				if (pend_q.size() > 0 && !(pend_q[0].drain && result_q.size() > 0) &&
				    ((in_cnt >= BURST_LO && in_cnt < BURST_HI) ||
				     $urandom_range(99) >= IDLE_PCT)) begin
					in_item  <= pend_q[0].item;
					in_valid <= 1'b1;
					void'(pend_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		ipd_pkg::out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			res_cnt   = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected transfer:", $time,
					         " ev=%0d data=%h len=%0d", out_item.event_res,
					         out_item.read_data, out_item.pkt_len);
					err_cnt++;
				end else begin
					want = result_q.pop_front();
					if (out_item.event_res !== want.event_res ||
					    out_item.read_data !== want.read_data ||
					    out_item.pkt_len !== want.pkt_len) begin
						$display("%0t: result %0d mismatch:", $time, res_cnt,
						         " expected ev=%0d data=%h len=%0d,", want.event_res,
						         want.read_data, want.pkt_len,
						         " got ev=%0d data=%h len=%0d", out_item.event_res,
						         out_item.read_data, out_item.pkt_len);
						err_cnt++;
					end
				end
				res_cnt++;
			end
			// stall once for a long stretch so the result queue backs up
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && res_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (res_cnt >= BURST_LO && res_cnt < BURST_HI) ||
				             ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_MAX) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	initial begin
		int goal;
		int pick;
		int n_pkt;
		err_cnt      = 0;
		quiet_cycles = 0;
		n_items      = 0;
		drain_next   = 1'b0;

		// directed: ignored bytes, short length fields, boundary length
		queue_item(1'b0, 8'h00, '0, 1'b0);
		queue_item(1'b0, 8'hFF, '1, 1'b0);
		queue_item(1'b0, 8'h44, '0, 1'b0);
		queue_packet(0, 1'b0);
		queue_read('0);
		queue_read(IW'(HDR));
		queue_packet(HDR, 1'b0);
		queue_packet(HDR + 1, 1'b0);
		queue_read(IW'(3));

		// largest packet that completes, then one that overflows the buffer
		drain_next = 1'b1;
		queue_packet(BUF, 1'b0);
		queue_packet(16'hFFFF, 1'b0);
		queue_read('1);
		queue_read('0);
		queue_packet(HDR + 2, 1'b0);

		// random: mostly well-formed packets, the whole buffer is now written
		goal  = n_items + RAND_ITEMS;
		n_pkt = 0;
		while (n_items < goal) begin
			if (n_pkt % 40 == 39)
				drain_next = 1'b1;
			pick = $urandom_range(99);
			if (pick < 8)
				queue_packet($urandom_range(HDR), 1'b1);
			else if (pick < 90)
				queue_packet($urandom_range(64, HDR + 1), 1'b1);
			else
				queue_packet($urandom_range(300, 65), 1'b1);
			n_pkt++;
			repeat ($urandom_range(2))
				queue_noise();
			if ($urandom_range(99) < 30)
				queue_read(IW'($urandom));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() > 0 || in_valid || result_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
